// ===== rtl/mffr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mffr_pkg
// Shared constants and types for the maze flood-fill router.
// ----------------------------------------------------------------------------
package mffr_pkg;
   localparam int MAZE_SIZE_DEF    = 16;
   localparam int CENTRE_INDEX_DEF = 8;
   localparam int STACK_DEPTH_DEF  = 64;
   localparam int DIST_MAX         = 255;
   localparam int POP_LIMIT        = 4194304;

   localparam logic REQ_WALL  = 1'b0;
   localparam logic REQ_FLOOD = 1'b1;

   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_E = 2'd1;
   localparam logic [1:0] DIR_S = 2'd2;
   localparam logic [1:0] DIR_W = 2'd3;

   typedef struct packed {
      logic       req_type;
      logic [3:0] row;
      logic [3:0] col;
      logic [1:0] wall_dir;
   } req_type_type;

   typedef struct packed {
      logic [3:0] next_row;
      logic [3:0] next_col;
      logic       stack_overflow;
   } rsp_type_type;
endpackage
`default_nettype wire

// ===== rtl/mffr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mffr_if
// Valid/ready channel carrying one packed item.
// ----------------------------------------------------------------------------
interface mffr_if #(parameter int WIDTH = 1);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/maze_flood_fill_router.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// maze_flood_fill_router
// Modified flood fill over a wall/distance grid held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: {req_type,row,col,wall_dir}. A wall item sets one wall bit
//  of an in-grid cell, with no result. A flood item runs the fill from an
//  in-grid cell; every flood item returns one rsp item
//  {next_row,next_col,stack_overflow}. Each pop runs pop, stack read, cell
//  read, 4 neighbour reads and a fold step, and evaluate, and then a push
//  step when the cell's distance changes and its neighbours are pushed. A
//  closing scan of the start cell follows the last pop, after which rsp is
//  valid, so the pop count of the fill sets the latency.
//  Reset: a clearing pass over all 256 cells writes the Manhattan distances
//  and clears the walls; req is not taken meanwhile.
//  A result waits in the output register; the next item is taken only once
//  it has been delivered, so a stalled receiver holds the block.
// ----------------------------------------------------------------------------
module maze_flood_fill_router
   import mffr_pkg::*;
#(
   parameter int MAZE_SIZE    = MAZE_SIZE_DEF,
   parameter int CENTRE_INDEX = CENTRE_INDEX_DEF,
   parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
   input  wire   clock,
   input  wire   reset,
   mffr_if.sink   req,
   mffr_if.source rsp
);
   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int SCW = $clog2(STACK_DEPTH + 1);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_WALLR = 4'd2;
   localparam logic [3:0] S_WALLW = 4'd3;
   localparam logic [3:0] S_POP   = 4'd4;
   localparam logic [3:0] S_SELF  = 4'd5;
   localparam logic [3:0] S_NBR   = 4'd6;
   localparam logic [3:0] S_EVAL  = 4'd7;
   localparam logic [3:0] S_PUSH  = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   // grid memory: {walls[3:0], dist[7:0]}
   logic [11:0] grid_mem [256];
   logic [11:0] grid_rd;
   logic [7:0]  grid_ra, grid_wa;
   logic [11:0] grid_wd;
   logic        grid_we;
   logic [7:0]  stk_mem [STACK_DEPTH];
   logic [7:0]  stk_rd;
   logic [SAW-1:0] stk_ra, stk_wa;
   logic        stk_we;
   logic [7:0]  stk_wd;

   always_ff @(posedge clock) begin
      if (grid_we) grid_mem[grid_wa] <= grid_wd;
      grid_rd <= grid_mem[grid_ra];
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      stk_rd <= stk_mem[stk_ra];
   end

   logic [3:0]  state_ff, state_in;
   logic [7:0]  idx_ff, idx_in;        // init sweep
   logic [SCW-1:0] cnt_ff, cnt_in;
   logic        ovf_ff, ovf_in;
   logic [22:0] pops_ff, pops_in;
   logic [3:0]  r_ff, r_in, c_ff, c_in; // current cell
   logic [3:0]  sr_ff, sr_in, sc_ff, sc_in; // start cell
   logic        fin_ff, fin_in;        // final neighbour scan
   logic [1:0]  wdir_ff, wdir_in;
   logic [3:0]  walls_ff, walls_in;
   logic [7:0]  dist_ff, dist_in;
   logic [2:0]  d_ff, d_in;            // neighbour step, 4 = read done
   logic        rdv_ff, rdv_in;        // a neighbour read is in flight
   logic [1:0]  rdd_ff, rdd_in;
   logic        fnd_ff, fnd_in;
   logic [7:0]  bd_ff, bd_in;
   logic [3:0]  br_ff, br_in, bc_ff, bc_in;
   logic [3:0]  or_ff, or_in, oc_ff, oc_in;
   logic        oo_ff, oo_in;

   req_type_type rq;
   assign rq = req.data;

   function automatic logic nb_ok(input logic [3:0] r, input logic [3:0] c,
                                  input logic [3:0] w, input logic [1:0] d);
      logic ok;
      ok = !w[d];
      unique case (d)
         DIR_N: ok = ok && (r != 4'd0);
         DIR_E: ok = ok && (5'(c) + 5'd1 < 5'(MAZE_SIZE));
         DIR_S: ok = ok && (5'(r) + 5'd1 < 5'(MAZE_SIZE));
         default: ok = ok && (c != 4'd0);
      endcase
      return ok;
   endfunction

   function automatic logic [7:0] nb_pos(input logic [3:0] r, input logic [3:0] c,
                                         input logic [1:0] d);
      logic [7:0] p;
      unique case (d)
         DIR_N: p = {r - 4'd1, c};
         DIR_E: p = {r, c + 4'd1};
         DIR_S: p = {r + 4'd1, c};
         default: p = {r, c - 4'd1};
      endcase
      return p;
   endfunction

   logic [3:0] ir, ic, ar, ac;
   logic [7:0] mdist, target;
   always_comb begin
      ir = idx_ff[7:4];
      ic = idx_ff[3:0];
      ar = (ir >= 4'(CENTRE_INDEX)) ? ir - 4'(CENTRE_INDEX) : 4'(CENTRE_INDEX) - ir;
      ac = (ic >= 4'(CENTRE_INDEX)) ? ic - 4'(CENTRE_INDEX) : 4'(CENTRE_INDEX) - ic;
      mdist = 8'(ar) + 8'(ac);
      target = (bd_ff == 8'(DIST_MAX)) ? 8'(DIST_MAX) : bd_ff + 8'd1;
   end

   logic in_grid;
   assign in_grid = (5'(rq.row) < 5'(MAZE_SIZE)) && (5'(rq.col) < 5'(MAZE_SIZE));
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = {or_ff, oc_ff, oo_ff};

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; cnt_in = cnt_ff; ovf_in = ovf_ff;
      pops_in = pops_ff; r_in = r_ff; c_in = c_ff; sr_in = sr_ff; sc_in = sc_ff;
      fin_in = fin_ff; wdir_in = wdir_ff; walls_in = walls_ff; dist_in = dist_ff;
      d_in = d_ff; rdv_in = 1'b0; rdd_in = rdd_ff; fnd_in = fnd_ff; bd_in = bd_ff;
      br_in = br_ff; bc_in = bc_ff; or_in = or_ff; oc_in = oc_ff; oo_in = oo_ff;
      grid_ra = {r_ff, c_ff}; grid_we = 1'b0; grid_wa = {r_ff, c_ff};
      grid_wd = {walls_ff, dist_ff};
      stk_ra = SAW'(cnt_ff - SCW'(1)); stk_we = 1'b0;
      stk_wa = cnt_ff[SAW-1:0]; stk_wd = 8'd0;
      unique case (state_ff)
         S_INIT: begin
            grid_we = 1'b1; grid_wa = idx_ff; grid_wd = {4'd0, mdist};
            idx_in = idx_ff + 8'd1;
            if (idx_ff == 8'hff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               r_in = rq.row; c_in = rq.col; sr_in = rq.row; sc_in = rq.col;
               wdir_in = rq.wall_dir;
               grid_ra = {rq.row, rq.col};
               if (rq.req_type == REQ_WALL) begin
                  if (in_grid) state_in = S_WALLR;
               end else if (!in_grid) begin
                  or_in = 4'd0; oc_in = 4'd0; oo_in = 1'b0; state_in = S_OUT;
               end else begin
                  ovf_in = 1'b0; pops_in = '0; fin_in = 1'b0;
                  // initial push of the start cell
                  stk_we = 1'b1; stk_wa = '0; stk_wd = {rq.row, rq.col};
                  cnt_in = SCW'(1);
                  state_in = S_POP;
               end
            end
         end
         S_WALLR: state_in = S_WALLW;
         S_WALLW: begin
            grid_we = 1'b1;
            grid_wd = grid_rd | (12'd1 << (4'd8 + 4'(wdir_ff)));
            state_in = S_IDLE;
         end
         S_POP: begin
            if (cnt_ff == '0 || pops_ff == 23'(POP_LIMIT)) begin
               cnt_in = '0; fin_in = 1'b1;
               r_in = sr_ff; c_in = sc_ff; grid_ra = {sr_ff, sc_ff};
               state_in = S_SELF;
            end else begin
               pops_in = pops_ff + 23'd1;
               cnt_in = cnt_ff - SCW'(1);
               state_in = S_FIN; // wait for stack read
            end
         end
         S_FIN: begin
            r_in = stk_rd[7:4]; c_in = stk_rd[3:0]; grid_ra = stk_rd;
            state_in = S_SELF;
         end
         S_SELF: begin
            walls_in = grid_rd[11:8]; dist_in = grid_rd[7:0];
            fnd_in = 1'b0; d_in = 3'd0; state_in = S_NBR;
         end
         S_NBR: begin
            // issue one neighbour read per cycle, fold the previous one
            if (rdv_ff && (!fnd_ff || grid_rd[7:0] < bd_ff)) begin
               fnd_in = 1'b1; bd_in = grid_rd[7:0];
               {br_in, bc_in} = nb_pos(r_ff, c_ff, rdd_ff);
            end
            if (d_ff[2]) begin
               state_in = S_EVAL;
            end else begin
               rdd_in = d_ff[1:0];
               rdv_in = nb_ok(r_ff, c_ff, walls_ff, d_ff[1:0]);
               grid_ra = nb_pos(r_ff, c_ff, d_ff[1:0]);
               d_in = d_ff + 3'd1;
            end
         end
         S_EVAL: begin
            if (fin_ff) begin
               or_in = fnd_ff ? br_ff : 4'd0; oc_in = fnd_ff ? bc_ff : 4'd0;
               oo_in = ovf_ff; state_in = S_OUT;
            end else if (!fnd_ff || dist_ff == target) begin
               state_in = S_POP;
            end else begin
               grid_we = 1'b1; grid_wd = {walls_ff, target};
               d_in = 3'd0; state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (d_ff[2]) begin
               state_in = S_POP;
            end else begin
               if (nb_ok(r_ff, c_ff, walls_ff, d_ff[1:0])) begin
                  if (cnt_ff < SCW'(STACK_DEPTH)) begin
                     stk_we = 1'b1; stk_wd = nb_pos(r_ff, c_ff, d_ff[1:0]);
                     cnt_in = cnt_ff + SCW'(1);
                  end else ovf_in = 1'b1;
               end
               d_in = d_ff + 3'd1;
            end
         end
         S_OUT: if (rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; idx_ff <= '0; cnt_ff <= '0; ovf_ff <= 1'b0;
         rdv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; idx_ff <= idx_in; cnt_ff <= cnt_in; ovf_ff <= ovf_in;
         rdv_ff <= rdv_in;
      end
      pops_ff <= pops_in; r_ff <= r_in; c_ff <= c_in; sr_ff <= sr_in; sc_ff <= sc_in;
      fin_ff <= fin_in; wdir_ff <= wdir_in; walls_ff <= walls_in; dist_ff <= dist_in;
      d_ff <= d_in; rdd_ff <= rdd_in; fnd_ff <= fnd_in; bd_ff <= bd_in;
      br_ff <= br_in; bc_ff <= bc_in; or_ff <= or_in; oc_ff <= oc_in; oo_ff <= oo_in;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SCW'(STACK_DEPTH)) else $error("stack count beyond depth");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while stalled");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      stk_we |-> cnt_ff < SCW'(STACK_DEPTH)) else $error("push onto full stack");
`endif
endmodule
`default_nettype wire
